@@ hdl/bj0_pkg.sv @@
`default_nettype none
package bj0_pkg;

    localparam int FRAC_BITS    = 48;
    localparam int TAYLOR_TERMS = 31;
    localparam int ASYM_TERMS   = 9;
    localparam int WORD_W       = 128;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [1:0] {
        SH_NONE,
        SH_34,
        SH_FRAC,
        SH_64
    } shift_sel_t;

    typedef struct packed {
        logic       start;
        shift_sel_t shift;
    } mul_req_t;

    typedef enum logic [5:0] {
        ST_IDLE, ST_SQ, ST_SQ_W, ST_SEL,
        ST_TM, ST_TM_W, ST_TD_W,
        ST_AR, ST_AR_W, ST_PP, ST_PP_W,
        ST_QD, ST_QD_W, ST_R2, ST_R2_W,
        ST_TRM, ST_TRM_W, ST_TRD_W, ST_SN, ST_SN_W,
        ST_INV, ST_INV_W, ST_MM, ST_MM_W, ST_SQR, ST_SQR_W,
        ST_T1, ST_T1_W, ST_T2, ST_T2_W, ST_T3, ST_T3_W, ST_T4, ST_T4_W,
        ST_FIN, ST_OUT
    } state_t;

    localparam word_t HALF_PI    = 128'h00000001921FB544_42D18469898CC517;
    localparam word_t QUARTER_PI = 128'h00000000C90FDAA2_2168C234C4C6628B;
    localparam word_t TWO_OVER_PI = 128'h0000000000000000_A2F9836E4E441529;
    localparam logic [63:0] ASYM_LIMIT = 64'd196 << 32;

    function automatic logic [63:0] taylor_threshold(input int idx);
        logic [31:0] v;
        case (idx)
            0: v = 32'd4;
            1: v = 32'd16;
            2: v = 32'd25;
            3: v = 32'd36;
            4: v = 32'd49;
            5: v = 32'd64;
            6: v = 32'd81;
            7: v = 32'd100;
            8: v = 32'd121;
            9: v = 32'd144;
            default: v = 32'd196;
        endcase
        return {v, 32'd0};
    endfunction

    function automatic logic [4:0] taylor_degree_of(input int idx);
        logic [4:0] d;
        case (idx)
            0: d = 5'd12;
            1: d = 5'd16;
            2: d = 5'd18;
            3: d = 5'd19;
            4: d = 5'd21;
            5: d = 5'd23;
            6: d = 5'd24;
            7: d = 5'd26;
            8: d = 5'd27;
            9: d = 5'd29;
            default: d = 5'd30;
        endcase
        return d;
    endfunction

    function automatic logic [4:0] taylor_degree(input logic [63:0] a);
        logic [4:0] d;
        d = 5'd0;
        for (int i = 10; i >= 0; i--) begin
            if (a < taylor_threshold(i)) begin
                d = taylor_degree_of(i);
            end
        end
        if (d > 5'(TAYLOR_TERMS - 1)) begin
            d = 5'(TAYLOR_TERMS - 1);
        end
        return d;
    endfunction

    function automatic word_t asym_coef(input logic [3:0] idx, input int fb);
        logic [63:0] num;
        int          ex;
        logic        neg;
        word_t       v;
        case (idx)
            4'd0: begin num = 64'd1; ex = 0; neg = 1'b0; end
            4'd1: begin num = 64'd1; ex = 3; neg = 1'b0; end
            4'd2: begin num = 64'd9; ex = 7; neg = 1'b1; end
            4'd3: begin num = 64'd75; ex = 10; neg = 1'b1; end
            4'd4: begin num = 64'd3675; ex = 15; neg = 1'b0; end
            4'd5: begin num = 64'd59535; ex = 18; neg = 1'b0; end
            4'd6: begin num = 64'd2401245; ex = 22; neg = 1'b1; end
            4'd7: begin num = 64'd57972915; ex = 25; neg = 1'b1; end
            4'd8: begin num = 64'd13043905875; ex = 31; neg = 1'b0; end
            default: begin num = 64'd0; ex = 0; neg = 1'b0; end
        endcase
        v = word_t'(num) << (fb - ex);
        return neg ? (~v + word_t'(1)) : v;
    endfunction

endpackage
`default_nettype wire

@@ hdl/bj0_mul.sv @@
`default_nettype none
module bj0_mul #(
    parameter int FRAC_W = bj0_pkg::FRAC_BITS
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire bj0_pkg::mul_req_t req,
    input  wire bj0_pkg::word_t   op_a,
    input  wire bj0_pkg::word_t   op_b,
    output bj0_pkg::word_t        prod,
    output logic                  done
);
    import bj0_pkg::*;

    logic       busy_reg, busy_next;
    logic       fin_reg, fin_next;
    logic       done_reg, done_next;
    logic [3:0] cnt_reg, cnt_next;
    word_t      a_reg, a_next;
    word_t      b_reg, b_next;
    word_t      acc_reg, acc_next;
    word_t      prod_reg, prod_next;
    logic       neg_reg, neg_next;
    shift_sel_t sh_reg, sh_next;

    logic [31:0] limb_a;
    logic [31:0] limb_b;
    logic [63:0] pp;
    logic [2:0]  lsum;
    word_t       addend;
    word_t       shifted;

    always_comb begin
        limb_a = a_reg[{cnt_reg[3:2], 5'd0} +: 32];
        limb_b = b_reg[{cnt_reg[1:0], 5'd0} +: 32];
        pp     = limb_a * limb_b;
        lsum   = {1'b0, cnt_reg[3:2]} + {1'b0, cnt_reg[1:0]};
        addend = (lsum <= 3'd3) ? (word_t'(pp) << {lsum[1:0], 5'd0}) : '0;
        case (sh_reg)
            SH_NONE: shifted = acc_reg;
            SH_34:   shifted = acc_reg >> 34;
            SH_FRAC: shifted = acc_reg >> FRAC_W;
            SH_64:   shifted = acc_reg >> 64;
            default: shifted = acc_reg;
        endcase
    end

    always_comb begin
        busy_next = busy_reg;
        fin_next  = 1'b0;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        prod_next = prod_reg;
        neg_next  = neg_reg;
        sh_next   = sh_reg;
        if (req.start) begin
            a_next    = op_a[WORD_W-1] ? (~op_a + word_t'(1)) : op_a;
            b_next    = op_b[WORD_W-1] ? (~op_b + word_t'(1)) : op_b;
            neg_next  = op_a[WORD_W-1] ^ op_b[WORD_W-1];
            sh_next   = req.shift;
            acc_next  = '0;
            cnt_next  = 4'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            acc_next = acc_reg + addend;
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd15) begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end else if (fin_reg) begin
            prod_next = neg_reg ? (~shifted + word_t'(1)) : shifted;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
        end
        cnt_reg  <= cnt_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        neg_reg  <= neg_next;
        sh_reg   <= sh_next;
    end

    assign prod = prod_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

@@ hdl/bj0_div.sv @@
`default_nettype none
module bj0_div (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           start,
    input  wire bj0_pkg::word_t num,
    input  wire bj0_pkg::word_t den,
    output bj0_pkg::word_t      quo,
    output bj0_pkg::word_t      rem,
    output logic                done
);
    import bj0_pkg::*;

    logic       busy_reg, busy_next;
    logic       done_reg, done_next;
    logic [6:0] cnt_reg, cnt_next;
    word_t      n_reg, n_next;
    word_t      d_reg, d_next;
    word_t      q_reg, q_next;
    word_t      r_reg, r_next;

    logic [WORD_W:0] rs;
    logic            fits;

    always_comb begin
        rs   = {r_reg, n_reg[WORD_W-1]};
        fits = rs >= {1'b0, d_reg};
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        n_next    = n_reg;
        d_next    = d_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        if (start) begin
            n_next    = num;
            d_next    = den;
            q_next    = '0;
            r_next    = '0;
            cnt_next  = 7'd127;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            r_next   = fits ? WORD_W'(rs - {1'b0, d_reg}) : rs[WORD_W-1:0];
            q_next   = {q_reg[WORD_W-2:0], fits};
            n_next   = {n_reg[WORD_W-2:0], 1'b0};
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        n_reg   <= n_next;
        d_reg   <= d_next;
        q_reg   <= q_next;
        r_reg   <= r_next;
    end

    assign quo  = q_reg;
    assign rem  = r_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

@@ hdl/bj0_sqrt.sv @@
`default_nettype none
module bj0_sqrt (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           start,
    input  wire bj0_pkg::word_t radicand,
    output bj0_pkg::word_t      root,
    output logic                done
);
    import bj0_pkg::*;

    logic       busy_reg, busy_next;
    logic       done_reg, done_next;
    logic [5:0] cnt_reg, cnt_next;
    word_t      n_reg, n_next;
    word_t      res_reg, res_next;
    word_t      bit_reg, bit_next;

    word_t trial;

    assign trial = res_reg + bit_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        n_next    = n_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        if (start) begin
            n_next    = radicand;
            res_next  = '0;
            bit_next  = word_t'(1) << 126;
            cnt_next  = 6'd63;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (n_reg >= trial) begin
                n_next   = n_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        n_reg   <= n_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign root = res_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

@@ hdl/bessel_j0_evaluator_unit.sv @@
`default_nettype none
// Computes J0(x) for a signed Q16.16 argument and returns a signed Q1.30 result,
// saturated to [-1, 1]. One argument is in flight at a time: s_tready is high only
// while the unit is idle, and the result is held on the master side until taken.
// Wide products, quotients and square roots run through an iterative 128-bit
// multiplier (built from one 32x32 multiplier), a radix-2 divider and a bit-pair
// square root. Arguments with x*x below 196 take the Taylor series with 12 to 30
// terms, one product and one quotient per Taylor term; larger arguments take the
// asymptotic path, whose run time is dominated by its 23 divisions.
module bessel_j0_evaluator_unit #(
    parameter int INTERNAL_FRAC_BITS = bj0_pkg::FRAC_BITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] x_in
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // [31:0] j0_out
);
    import bj0_pkg::*;

    localparam word_t ONE = word_t'(1) << INTERNAL_FRAC_BITS;
    localparam word_t RND = word_t'(1) << (INTERNAL_FRAC_BITS - 31);
    localparam word_t LIM = word_t'(1) << 30;

    state_t state_reg, state_next;

    logic [31:0] u_reg, u_next;
    logic [63:0] a_reg, a_next;
    logic [4:0]  k_reg, k_next;
    logic [3:0]  idx_reg, idx_next;
    logic        cos_reg, cos_next;
    logic [1:0]  quad_reg, quad_next;
    logic        sgn_reg, sgn_next;
    word_t       acc_reg, acc_next;
    word_t       r_reg, r_next;
    word_t       pv_reg, pv_next;
    word_t       qv_reg, qv_next;
    word_t       rho_reg, rho_next;
    word_t       r2_reg, r2_next;
    word_t       sn_reg, sn_next;
    word_t       sth_reg, sth_next;
    word_t       cth_reg, cth_next;
    word_t       invx_reg, invx_next;
    word_t       rsq_reg, rsq_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [31:0] m_tdata_reg, m_tdata_next;

    mul_req_t mul_req;
    word_t    mul_a, mul_b, mul_prod;
    logic     mul_done;
    logic     div_start, div_done;
    word_t    div_n, div_d, div_q, div_r;
    logic     sqrt_start, sqrt_done;
    word_t    sqrt_n, sqrt_root;

    word_t       prod_mag;
    word_t       q_applied;
    word_t       poly_val;
    word_t       rho_diff;
    word_t       fin_sh;
    word_t       fin_mag;
    logic [31:0] u_in;
    logic [4:0]  deg;
    logic [9:0]  jj;
    logic [9:0]  trig_den;

    bj0_mul #(.FRAC_W(INTERNAL_FRAC_BITS)) u_mul (
        .aclk(aclk), .aresetn(aresetn), .req(mul_req),
        .op_a(mul_a), .op_b(mul_b), .prod(mul_prod), .done(mul_done)
    );

    bj0_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(div_n), .den(div_d), .quo(div_q), .rem(div_r), .done(div_done)
    );

    bj0_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sqrt_start),
        .radicand(sqrt_n), .root(sqrt_root), .done(sqrt_done)
    );

    always_comb begin
        u_in      = s_tdata[31] ? (~s_tdata + 32'd1) : s_tdata;
        deg       = taylor_degree(a_reg);
        prod_mag  = mul_prod[WORD_W-1] ? (~mul_prod + word_t'(1)) : mul_prod;
        q_applied = acc_reg;
        poly_val  = mul_prod + asym_coef(idx_reg, INTERNAL_FRAC_BITS);
        rho_diff  = div_r - QUARTER_PI;
        jj        = {4'd0, k_reg, 1'b0};
        trig_den  = cos_reg ? ((jj - 10'd1) * jj) : (jj * (jj + 10'd1));
        fin_sh    = word_t'($signed(acc_reg + RND) >>> (INTERNAL_FRAC_BITS - 30));
        fin_mag   = fin_sh[WORD_W-1] ? (~fin_sh + word_t'(1)) : fin_sh;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_SQ;
            ST_SQ:    state_next = ST_SQ_W;
            ST_SQ_W:  if (mul_done) state_next = ST_SEL;
            ST_SEL:   state_next = (a_reg < ASYM_LIMIT) ? ST_TM : ST_AR;
            ST_TM:    state_next = ST_TM_W;
            ST_TM_W:  if (mul_done) state_next = ST_TD_W;
            ST_TD_W: begin
                if (div_done) state_next = (k_reg == 5'd1) ? ST_FIN : ST_TM;
            end
            ST_AR:    state_next = ST_AR_W;
            ST_AR_W:  if (div_done) state_next = ST_PP;
            ST_PP:    state_next = ST_PP_W;
            ST_PP_W: begin
                if (mul_done) state_next = (idx_reg == 4'd1) ? ST_QD : ST_PP;
            end
            ST_QD:    state_next = ST_QD_W;
            ST_QD_W:  if (div_done) state_next = ST_R2;
            ST_R2:    state_next = ST_R2_W;
            ST_R2_W:  if (mul_done) state_next = ST_TRM;
            ST_TRM:   state_next = ST_TRM_W;
            ST_TRM_W: if (mul_done) state_next = ST_TRD_W;
            ST_TRD_W: begin
                if (div_done) begin
                    if (k_reg != 5'd1) begin
                        state_next = ST_TRM;
                    end else begin
                        state_next = cos_reg ? ST_INV : ST_SN;
                    end
                end
            end
            ST_SN:    state_next = ST_SN_W;
            ST_SN_W:  if (mul_done) state_next = ST_TRM;
            ST_INV:   state_next = ST_INV_W;
            ST_INV_W: if (div_done) state_next = ST_MM;
            ST_MM:    state_next = ST_MM_W;
            ST_MM_W:  if (mul_done) state_next = ST_SQR;
            ST_SQR:   state_next = ST_SQR_W;
            ST_SQR_W: if (sqrt_done) state_next = ST_T1;
            ST_T1:    state_next = ST_T1_W;
            ST_T1_W:  if (mul_done) state_next = ST_T2;
            ST_T2:    state_next = ST_T2_W;
            ST_T2_W:  if (mul_done) state_next = ST_T3;
            ST_T3:    state_next = ST_T3_W;
            ST_T3_W:  if (mul_done) state_next = ST_T4;
            ST_T4:    state_next = ST_T4_W;
            ST_T4_W:  if (mul_done) state_next = ST_FIN;
            ST_FIN:   state_next = ST_OUT;
            ST_OUT:   if (m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Unit requests.
    always_comb begin
        mul_req    = '{start: 1'b0, shift: SH_FRAC};
        mul_a      = acc_reg;
        mul_b      = r_reg;
        div_start  = 1'b0;
        div_n      = prod_mag;
        div_d      = word_t'(trig_den);
        sqrt_start = 1'b0;
        sqrt_n     = r_reg << INTERNAL_FRAC_BITS;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_SQ: begin
                mul_req = '{start: 1'b1, shift: SH_NONE};
                mul_a   = word_t'(u_reg);
                mul_b   = word_t'(u_reg);
            end
            ST_TM: begin
                mul_req = '{start: 1'b1, shift: SH_34};
                mul_b   = word_t'(a_reg);
            end
            ST_TM_W: begin
                div_start = mul_done;
                div_d     = word_t'({5'd0, k_reg} * {5'd0, k_reg});
            end
            ST_AR: begin
                div_start = 1'b1;
                div_n     = ONE << 32;
                div_d     = word_t'(a_reg);
            end
            ST_PP: mul_req = '{start: 1'b1, shift: SH_FRAC};
            ST_QD: begin
                div_start = 1'b1;
                div_n     = word_t'(u_reg) << 80;
                div_d     = HALF_PI;
            end
            ST_R2: begin
                mul_req = '{start: 1'b1, shift: SH_FRAC};
                mul_a   = rho_reg;
                mul_b   = rho_reg;
            end
            ST_TRM: begin
                mul_req = '{start: 1'b1, shift: SH_FRAC};
                mul_b   = r2_reg;
            end
            ST_TRM_W: div_start = mul_done;
            ST_SN: begin
                mul_req = '{start: 1'b1, shift: SH_FRAC};
                mul_a   = rho_reg;
                mul_b   = acc_reg;
            end
            ST_INV: begin
                div_start = 1'b1;
                div_n     = ONE << 16;
                div_d     = word_t'(u_reg);
            end
            ST_MM: begin
                mul_req = '{start: 1'b1, shift: SH_64};
                mul_a   = invx_reg;
                mul_b   = TWO_OVER_PI;
            end
            ST_SQR: sqrt_start = 1'b1;
            ST_T1: begin
                mul_req = '{start: 1'b1, shift: SH_FRAC};
                mul_a   = pv_reg;
                mul_b   = cth_reg;
            end
            ST_T2: begin
                mul_req = '{start: 1'b1, shift: SH_FRAC};
                mul_a   = qv_reg;
                mul_b   = sth_reg;
            end
            ST_T3: begin
                mul_req = '{start: 1'b1, shift: SH_FRAC};
                mul_a   = r2_reg;
                mul_b   = invx_reg;
            end
            ST_T4: begin
                mul_req = '{start: 1'b1, shift: SH_FRAC};
                mul_b   = rsq_reg;
            end
            default: ;
        endcase
    end

    // Datapath registers.
    always_comb begin
        u_next        = u_reg;
        a_next        = a_reg;
        k_next        = k_reg;
        idx_next      = idx_reg;
        cos_next      = cos_reg;
        quad_next     = quad_reg;
        sgn_next      = sgn_reg;
        acc_next      = acc_reg;
        r_next        = r_reg;
        pv_next       = pv_reg;
        qv_next       = qv_reg;
        rho_next      = rho_reg;
        r2_next       = r2_reg;
        sn_next       = sn_reg;
        sth_next      = sth_reg;
        cth_next      = cth_reg;
        invx_next     = invx_reg;
        rsq_next      = rsq_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        case (state_reg)
            ST_IDLE: if (s_tvalid) u_next = u_in;
            ST_SQ_W: if (mul_done) a_next = mul_prod[63:0];
            ST_SEL: begin
                acc_next = ONE;
                k_next   = deg;
            end
            ST_TM_W: if (mul_done) sgn_next = mul_prod[WORD_W-1];
            ST_TD_W, ST_TRD_W: begin
                if (div_done) begin
                    acc_next = sgn_reg ? (ONE + div_q) : (ONE - div_q);
                    k_next   = k_reg - 5'd1;
                    if (state_reg == ST_TRD_W && k_reg == 5'd1 && cos_reg) begin
                        case (quad_reg)
                            2'd0: begin
                                sth_next = sn_reg;
                                cth_next = sgn_reg ? (ONE + div_q) : (ONE - div_q);
                            end
                            2'd1: begin
                                sth_next = sgn_reg ? (ONE + div_q) : (ONE - div_q);
                                cth_next = ~sn_reg + word_t'(1);
                            end
                            2'd2: begin
                                sth_next = ~sn_reg + word_t'(1);
                                cth_next = sgn_reg ? (~(ONE + div_q) + word_t'(1))
                                                   : (div_q - ONE);
                            end
                            default: begin
                                sth_next = sgn_reg ? (~(ONE + div_q) + word_t'(1))
                                                   : (div_q - ONE);
                                cth_next = sn_reg;
                            end
                        endcase
                    end
                end
            end
            ST_AR_W: begin
                if (div_done) begin
                    r_next   = div_q;
                    acc_next = asym_coef(4'd8, INTERNAL_FRAC_BITS);
                    idx_next = 4'd6;
                end
            end
            ST_PP_W: begin
                if (mul_done) begin
                    acc_next = poly_val;
                    idx_next = idx_reg - 4'd2;
                    if (idx_reg == 4'd0) begin
                        pv_next  = poly_val;
                        acc_next = asym_coef(4'd7, INTERNAL_FRAC_BITS);
                        idx_next = 4'd5;
                    end else if (idx_reg == 4'd1) begin
                        qv_next = poly_val;
                    end
                end
            end
            ST_QD_W: begin
                if (div_done) begin
                    quad_next = div_q[1:0];
                    rho_next  = word_t'($signed(rho_diff) >>> (96 - INTERNAL_FRAC_BITS));
                end
            end
            ST_R2_W: begin
                if (mul_done) begin
                    r2_next  = mul_prod;
                    acc_next = ONE;
                    k_next   = 5'd10;
                    cos_next = 1'b0;
                end
            end
            ST_TRM_W: if (mul_done) sgn_next = mul_prod[WORD_W-1];
            ST_SN_W: begin
                if (mul_done) begin
                    sn_next  = mul_prod;
                    acc_next = ONE;
                    k_next   = 5'd10;
                    cos_next = 1'b1;
                end
            end
            ST_INV_W: if (div_done) invx_next = div_q;
            ST_MM_W:  if (mul_done) r_next = mul_prod;
            ST_SQR_W: if (sqrt_done) rsq_next = sqrt_root;
            ST_T1_W:  if (mul_done) acc_next = mul_prod;
            ST_T2_W:  if (mul_done) r2_next = mul_prod;
            ST_T3_W:  if (mul_done) acc_next = q_applied + mul_prod;
            ST_T4_W:  if (mul_done) acc_next = mul_prod;
            ST_FIN: begin
                m_tvalid_next = 1'b1;
                if (fin_mag > LIM) begin
                    m_tdata_next = fin_sh[WORD_W-1] ? 32'(~LIM + word_t'(1)) : 32'(LIM);
                end else begin
                    m_tdata_next = fin_sh[31:0];
                end
            end
            ST_OUT: if (m_tready) m_tvalid_next = 1'b0;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        u_reg       <= u_next;
        a_reg       <= a_next;
        k_reg       <= k_next;
        idx_reg     <= idx_next;
        cos_reg     <= cos_next;
        quad_reg    <= quad_next;
        sgn_reg     <= sgn_next;
        acc_reg     <= acc_next;
        r_reg       <= r_next;
        pv_reg      <= pv_next;
        qv_reg      <= qv_next;
        rho_reg     <= rho_next;
        r2_reg      <= r2_next;
        sn_reg      <= sn_next;
        sth_reg     <= sth_next;
        cth_reg     <= cth_next;
        invx_reg    <= invx_next;
        rsq_reg     <= rsq_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef NO_ASSERTIONS
    a_ready_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("Input ready while a result is pending.");

    a_accept_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("Unit stayed ready after accepting an argument.");

    a_one_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mul_req.start && div_start))
        else $error("Multiplier and divider started together.");

    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata) <= 32'sd1073741824 &&
                      $signed(m_tdata) >= -32'sd1073741824))
        else $error("Result outside saturation range.");
`endif

endmodule
`default_nettype wire
